>>> src/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants for the infrared pulse-width packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package irpd_pkg;

  localparam int COUNT_BITS  = 16;
  localparam int GAP_TIMEOUT = 1500;

  localparam int SYM_W     = 16;
  localparam int GAP_REG_W = 11;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int KIND_W    = 3;
  localparam int NUM_SYM   = 6;

  localparam int GAP_W = $clog2(GAP_TIMEOUT + 2);
  localparam int CMP_W = ((COUNT_BITS > SYM_W) ? COUNT_BITS : SYM_W) + 1;
  localparam int GCMP_W = (GAP_W > GAP_REG_W) ? GAP_W : GAP_REG_W;

  localparam logic [KIND_W-1:0] KIND_ERROR = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_NOM = 3'd0,
    REG_TOLERANCE = 3'd1,
    REG_GAP_MIN   = 3'd2,
    REG_GAP_MAX   = 3'd3,
    REG_SYM_12    = 3'd4,
    REG_SYM_34    = 3'd5,
    REG_SYM_56    = 3'd6
  } cfg_reg_e;

  localparam logic [SYM_W-1:0]     RST_START_NOM = 16'd400;
  localparam logic [SYM_W-1:0]     RST_TOLERANCE = 16'd40;
  localparam logic [GAP_REG_W-1:0] RST_GAP_MIN   = 11'd100;
  localparam logic [GAP_REG_W-1:0] RST_GAP_MAX   = 11'd300;
  localparam logic [CFG_W-1:0]     RST_SYM_12    = 32'd13107300;
  localparam logic [CFG_W-1:0]     RST_SYM_34    = 32'd26214700;
  localparam logic [CFG_W-1:0]     RST_SYM_56    = 32'd39322100;

  typedef enum logic [3:0] {
    PH_WAIT_IDLE  = 4'd0,
    PH_IDLE       = 4'd1,
    PH_START_MARK = 4'd2,
    PH_START_GAP  = 4'd3,
    PH_D1_MARK    = 4'd4,
    PH_D1_GAP     = 4'd5,
    PH_D2_MARK    = 4'd6,
    PH_D2_GAP     = 4'd7,
    PH_STOP_MARK  = 4'd8
  } phase_e;

  typedef struct packed {
    logic [SYM_W-1:0]               start_nom;
    logic [SYM_W-1:0]               tolerance;
    logic [GAP_REG_W-1:0]           gap_min;
    logic [GAP_REG_W-1:0]           gap_max;
    logic [NUM_SYM-1:0][SYM_W-1:0]  sym_width;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
  } res_t;

endpackage

`default_nettype wire

>>> src/irpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// irpd_cfg_regs
// Configuration register file: write-only, one register per write.
// ----------------------------------------------------------------------------
`default_nettype none

module irpd_cfg_regs
  import irpd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output cfg_t                      cfg_o
);

  logic [SYM_W-1:0]     start_nom_q, start_nom_d;
  logic [SYM_W-1:0]     tolerance_q, tolerance_d;
  logic [GAP_REG_W-1:0] gap_min_q, gap_min_d;
  logic [GAP_REG_W-1:0] gap_max_q, gap_max_d;
  logic [CFG_W-1:0]     sym_12_q, sym_12_d;
  logic [CFG_W-1:0]     sym_34_q, sym_34_d;
  logic [CFG_W-1:0]     sym_56_q, sym_56_d;

  always_comb begin
    start_nom_d = start_nom_q;
    tolerance_d = tolerance_q;
    gap_min_d   = gap_min_q;
    gap_max_d   = gap_max_q;
    sym_12_d    = sym_12_q;
    sym_34_d    = sym_34_q;
    sym_56_d    = sym_56_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START_NOM: start_nom_d = cfg_wdata_i[SYM_W-1:0];
        REG_TOLERANCE: tolerance_d = cfg_wdata_i[SYM_W-1:0];
        REG_GAP_MIN:   gap_min_d   = cfg_wdata_i[GAP_REG_W-1:0];
        REG_GAP_MAX:   gap_max_d   = cfg_wdata_i[GAP_REG_W-1:0];
        REG_SYM_12:    sym_12_d    = cfg_wdata_i;
        REG_SYM_34:    sym_34_d    = cfg_wdata_i;
        REG_SYM_56:    sym_56_d    = cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_nom_q <= RST_START_NOM;
      tolerance_q <= RST_TOLERANCE;
      gap_min_q   <= RST_GAP_MIN;
      gap_max_q   <= RST_GAP_MAX;
      sym_12_q    <= RST_SYM_12;
      sym_34_q    <= RST_SYM_34;
      sym_56_q    <= RST_SYM_56;
    end else begin
      start_nom_q <= start_nom_d;
      tolerance_q <= tolerance_d;
      gap_min_q   <= gap_min_d;
      gap_max_q   <= gap_max_d;
      sym_12_q    <= sym_12_d;
      sym_34_q    <= sym_34_d;
      sym_56_q    <= sym_56_d;
    end
  end

  always_comb begin
    cfg_o.start_nom    = start_nom_q;
    cfg_o.tolerance    = tolerance_q;
    cfg_o.gap_min      = gap_min_q;
    cfg_o.gap_max      = gap_max_q;
    cfg_o.sym_width[0] = sym_12_q[SYM_W-1:0];
    cfg_o.sym_width[1] = sym_12_q[CFG_W-1:SYM_W];
    cfg_o.sym_width[2] = sym_34_q[SYM_W-1:0];
    cfg_o.sym_width[3] = sym_34_q[CFG_W-1:SYM_W];
    cfg_o.sym_width[4] = sym_56_q[SYM_W-1:0];
    cfg_o.sym_width[5] = sym_56_q[CFG_W-1:SYM_W];
  end

endmodule

`default_nettype wire

>>> src/irpd_classify.sv
// ----------------------------------------------------------------------------
// irpd_classify
// Frame classifier: start mark tolerance check and symbol match of both
// data marks against the six nominal widths.
// ----------------------------------------------------------------------------
`default_nettype none

module irpd_classify
  import irpd_pkg::*;
(
  input  cfg_t                        cfg_i,
  input  wire logic [COUNT_BITS-1:0]  start_count_i,
  input  wire logic [COUNT_BITS-1:0]  first_count_i,
  input  wire logic [COUNT_BITS-1:0]  second_count_i,
  output logic      [KIND_W-1:0]      kind_o
);

  function automatic logic fits_strict(input logic [CMP_W-1:0] d,
                                       input logic [CMP_W-1:0] w,
                                       input logic [CMP_W-1:0] t);
    return ((d + t) > w) && (d < (w + t));
  endfunction

  logic [CMP_W-1:0] s_ext, nom_ext, tol_ext, d1_ext, d2_ext;
  logic             start_ok;

  assign s_ext   = CMP_W'(start_count_i);
  assign d1_ext  = CMP_W'(first_count_i);
  assign d2_ext  = CMP_W'(second_count_i);
  assign nom_ext = CMP_W'(cfg_i.start_nom);
  assign tol_ext = CMP_W'(cfg_i.tolerance);

  assign start_ok = !(s_ext > (nom_ext + tol_ext)) && !((s_ext + tol_ext) < nom_ext);

  always_comb begin
    logic [CMP_W-1:0] w_ext;
    kind_o = KIND_ERROR;
    // lowest matching symbol wins
    for (int k = NUM_SYM - 1; k >= 0; k--) begin
      w_ext = CMP_W'(cfg_i.sym_width[k]);
      if (fits_strict(d1_ext, w_ext, tol_ext) && fits_strict(d2_ext, w_ext, tol_ext)) begin
        kind_o = KIND_W'(k + 1);
      end
    end
    if (!start_ok) begin
      kind_o = KIND_ERROR;
    end
  end

endmodule

`default_nettype wire

>>> src/irpd_fsm.sv
// ----------------------------------------------------------------------------
// irpd_fsm
// Frame phase tracker: mark and gap counters, start gap window check and
// result request on frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module irpd_fsm
  import irpd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire logic level_i,
  input  cfg_t      cfg_i,
  output res_t      res_o
);

  localparam logic [GAP_W-1:0]      GAP_LIMIT = GAP_W'(GAP_TIMEOUT);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [GAP_W-1:0]      GAP_ONE   = GAP_W'(1);

  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] start_q, start_d;
  logic [COUNT_BITS-1:0] first_q, first_d;
  logic [COUNT_BITS-1:0] second_q, second_d;
  logic [GAP_W-1:0]      gap_q, gap_d;

  logic [GAP_W-1:0]      gap_inc;
  logic [GAP_W-1:0]      gap_eval;
  logic                  timeout;
  logic                  gap_bad;
  logic                  idle;
  logic [KIND_W-1:0]     kind;

  assign idle     = level_i;
  assign gap_inc  = gap_q + GAP_ONE;
  assign timeout  = gap_inc > GAP_LIMIT;
  assign gap_eval = idle ? gap_inc : gap_q;
  assign gap_bad  = (GCMP_W'(gap_eval) > GCMP_W'(cfg_i.gap_max))
                 || (GCMP_W'(gap_eval) < GCMP_W'(cfg_i.gap_min));

  irpd_classify u_classify (
    .cfg_i          (cfg_i),
    .start_count_i  (start_q),
    .first_count_i  (first_q),
    .second_count_i (second_q),
    .kind_o         (kind)
  );

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      unique case (phase_q)
        PH_WAIT_IDLE:  if (idle) phase_d = PH_IDLE;
        PH_IDLE:       if (!idle) phase_d = PH_START_MARK;
        PH_START_MARK: if (idle) phase_d = PH_START_GAP;
        PH_START_GAP: begin
          if (!idle || timeout) begin
            if (gap_bad) begin
              phase_d = idle ? PH_IDLE : PH_WAIT_IDLE;
            end else begin
              phase_d = PH_D1_MARK;
            end
          end
        end
        PH_D1_MARK:    if (idle) phase_d = PH_D1_GAP;
        PH_D1_GAP:     if (!idle || timeout) phase_d = PH_D2_MARK;
        PH_D2_MARK:    if (idle) phase_d = PH_D2_GAP;
        PH_D2_GAP: begin
          if (!idle) begin
            phase_d = PH_STOP_MARK;
          end else if (timeout) begin
            phase_d = PH_IDLE;
          end
        end
        PH_STOP_MARK:  if (idle) phase_d = PH_IDLE;
        default:       phase_d = PH_WAIT_IDLE;
      endcase
    end
  end

  // counters and result request
  always_comb begin
    start_d   = start_q;
    first_d   = first_q;
    second_d  = second_q;
    gap_d     = gap_q;
    res_o     = '0;
    res_o.kind = kind;
    if (step_i) begin
      unique case (phase_q)
        PH_WAIT_IDLE: ;
        PH_IDLE: begin
          if (!idle) begin
            start_d  = COUNT_ONE;
            first_d  = '0;
            second_d = '0;
            gap_d    = '0;
          end
        end
        PH_START_MARK: begin
          if (!idle) begin
            start_d = (start_q == COUNT_MAX) ? start_q : start_q + COUNT_ONE;
          end else begin
            gap_d = GAP_ONE;
          end
        end
        PH_START_GAP: begin
          if (idle && !timeout) begin
            gap_d = gap_inc;
          end else if (gap_bad) begin
            res_o.valid = 1'b1;
            res_o.kind  = KIND_ERROR;
            start_d     = '0;
            first_d     = '0;
            second_d    = '0;
            gap_d       = '0;
          end else begin
            gap_d   = '0;
            first_d = idle ? '0 : COUNT_ONE;
          end
        end
        PH_D1_MARK: begin
          if (!idle) begin
            first_d = (first_q == COUNT_MAX) ? first_q : first_q + COUNT_ONE;
          end else begin
            gap_d = GAP_ONE;
          end
        end
        PH_D1_GAP: begin
          if (!idle) begin
            gap_d    = '0;
            second_d = COUNT_ONE;
          end else if (timeout) begin
            gap_d = '0;
          end else begin
            gap_d = gap_inc;
          end
        end
        PH_D2_MARK: begin
          if (!idle) begin
            second_d = (second_q == COUNT_MAX) ? second_q : second_q + COUNT_ONE;
          end else begin
            gap_d = GAP_ONE;
          end
        end
        PH_D2_GAP: begin
          if (!idle) begin
            gap_d = '0;
          end else if (timeout) begin
            res_o.valid = 1'b1;
            start_d     = '0;
            first_d     = '0;
            second_d    = '0;
            gap_d       = '0;
          end else begin
            gap_d = gap_inc;
          end
        end
        PH_STOP_MARK: begin
          if (idle) begin
            res_o.valid = 1'b1;
            start_d     = '0;
            first_d     = '0;
            second_d    = '0;
            gap_d       = '0;
          end
        end
        default: begin
          start_d  = '0;
          first_d  = '0;
          second_d = '0;
          gap_d    = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT_IDLE;
      start_q  <= '0;
      first_q  <= '0;
      second_q <= '0;
      gap_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      start_q  <= start_d;
      first_q  <= first_d;
      second_q <= second_d;
      gap_q    <= gap_d;
    end
  end

  a_res_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (phase_q == PH_START_GAP || phase_q == PH_D2_GAP
                     || phase_q == PH_STOP_MARK))
    else $error("result request outside a frame-ending phase");

  a_gap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_q <= GAP_LIMIT)
    else $error("gap counter beyond timeout");

  a_res_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> (start_q == '0 && first_q == '0 && second_q == '0
                     && gap_q == '0 && phase_q != PH_START_MARK))
    else $error("counters not cleared after result");

endmodule

`default_nettype wire

>>> src/ir_pulse_width_packet_decoder_unit.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_packet_decoder_unit
// Infrared pulse-width packet decoder: one receiver sample per request,
// one packet kind per decoded or rejected frame.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata bits (low first)      | note
//  s_axis   | in  | [0] ir_level, [7:1] zero    | one sample per request
//  m_axis   | out | [2:0] packet_kind, [7:3] 0  | 0 error, 1..6 symbol
//  cfg      | in  | we, index[2:0], wdata[31:0] | write only, no wait
//
//  One sample is taken every cycle unless a held result stalls the input;
//  the sample that ends a frame passes the input register, then the phase
//  logic into the result register. Reset loads the default registers and
//  waits for an idle line. While m_axis_tready_i is low with a result held,
//  the phase logic halts and the input register holds one further sample.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_width_packet_decoder_unit
  import irpd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [7:0]           s_axis_tdata_i,   // [0] ir_level
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic      [7:0]           m_axis_tdata_o,   // [2:0] packet_kind
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  cfg_t              cfg;
  res_t              res;
  logic              in_valid_q, in_valid_d;
  logic              in_level_q;
  logic              out_valid_q, out_valid_d;
  logic [KIND_W-1:0] out_kind_q;
  logic              in_take;
  logic              consume;

  irpd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign consume         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || consume;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  irpd_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (consume),
    .level_i (in_level_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_level_q <= s_axis_tdata_i[0];
    end
    if (res.valid) begin
      out_kind_q <= res.kind;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(8 - KIND_W){1'b0}}, out_kind_q};

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !res.valid)
    else $error("result overwrites a held result");

endmodule

`default_nettype wire
